// ----- sv/assert_macros.svh -----
// Assertion macros shared by the rate estimator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off while reset is low.
`define ASSERT_IMPL(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Condition on one edge implies a property on the next edge.
`define ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- sv/ewma_rate_pkg.sv -----
// Package: widths, constants, status codes and sequencer states of the rate estimator.
package ewma_rate_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int TIME_WIDTH  = 48;
	localparam int RATE_W      = 48;
	localparam int WEIGHT_W    = 17;
	localparam int FRAC_W      = 16;
	localparam int US_W        = 20;
	localparam int PROD_W      = COUNT_WIDTH + US_W;
	localparam int NUM_W       = PROD_W + FRAC_W;
	localparam int STEP_CNT_W  = $clog2(NUM_W);
	localparam int DELTA_W     = RATE_W + 1;

	localparam logic [PROD_W-1:0]   US_PER_S     = PROD_W'(1000000);
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = WEIGHT_W'(65536);
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(8192);
	localparam logic [RATE_W-1:0]   RATE_POS_MAX = {1'b0, {(RATE_W-1){1'b1}}};
	localparam logic [RATE_W-1:0]   RATE_NEG_MAG = {1'b1, {(RATE_W-1){1'b0}}};
	localparam logic [STEP_CNT_W-1:0] DIV_LAST_STEP = STEP_CNT_W'(NUM_W - 1);

	typedef enum logic [1:0] {
		STAT_FIRST   = 2'd0,
		STAT_UPDATED = 2'd1,
		STAT_HELD    = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_SAT,
		ST_DELTA,
		ST_SMUL,
		ST_UPD,
		ST_RES
	} state_t;

endpackage

// ----- sv/ewma_rate_estimator_core.sv -----
// Top level: EWMA event-rate estimator with an iterative restoring divider.
//
// channel  direction  signals                     payload
// s_*      in         s_tvalid/s_tready/s_tdata   counter_value, timestamp_us
// m_*      out        m_tvalid/m_tready/m_tdata   rate; m_tuser: status, saturated
// cfg_*    in         cfg_valid/cfg_ready         cfg_data: smoothing_weight
//
// A normal sample is worked through the states PREP, MUL, DIV, SAT, DELTA, SMUL,
// UPD and RES after its transfer: the restoring divider retires one quotient bit a cycle.
// The first sample goes straight to RES, and a sample with zero elapsed time goes from PREP to RES.
// s_tready is high only while the sequencer is idle; a result waiting on m_tready
// holds the sequencer in its final state once the next sample has been worked.
// Reset clears the stored sample, the smoothed rate and sets the weight to 8192.
module ewma_rate_estimator_core
	import ewma_rate_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [31:0] counter_value, [79:32] timestamp_us
	input  logic [COUNT_WIDTH+TIME_WIDTH-1:0] s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [47:0] rate
	output logic [RATE_W-1:0]      m_tdata,
	// [1:0] status, [2] saturated
	output logic [2:0]             m_tuser,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [WEIGHT_W-1:0]    cfg_data
);

	state_t state_q, state_d;

	logic [WEIGHT_W-1:0]    weight_q;
	logic [COUNT_WIDTH-1:0] last_count_q;
	logic [TIME_WIDTH-1:0]  last_time_q;
	logic                   have_sample_q;
	logic [RATE_W-1:0]      smoothed_q;

	logic [TIME_WIDTH-1:0]  dt_q;
	logic [COUNT_WIDTH-1:0] dv_q;
	logic                   neg_q;
	logic [COUNT_WIDTH-1:0] mag_q;
	logic [NUM_W-1:0]       num_q;
	logic [TIME_WIDTH-1:0]  rem_q;
	logic [RATE_W-1:0]      quo_q;
	logic                   ovf_q;
	logic [STEP_CNT_W-1:0]  div_cnt_q;
	logic [RATE_W-1:0]      inst_q;
	logic                   dneg_q;
	logic [DELTA_W-1:0]     absd_q;
	logic [DELTA_W-1:0]     step_q;
	status_t                status_q;
	logic                   sat_q;

	logic                   m_tvalid_q;
	logic [RATE_W-1:0]      m_rate_q;
	status_t                m_status_q;
	logic                   m_sat_q;

	logic in_xfer;
	logic out_load;

	logic [COUNT_WIDTH-1:0] in_count;
	logic [TIME_WIDTH-1:0]  in_time;

	logic [TIME_WIDTH:0]    rem_sh;
	logic [TIME_WIDTH:0]    rem_diff;
	logic                   rem_ge;

	logic [RATE_W-1:0]      lim;
	logic                   over;
	logic [RATE_W-1:0]      qsat;
	logic [DELTA_W-1:0]     delta;
	logic [WEIGHT_W-1:0]    w_eff;
	logic [DELTA_W+WEIGHT_W-1:0] smul;
	logic [DELTA_W-1:0]     upd_sum;

	assign in_count = s_tdata[COUNT_WIDTH-1:0];
	assign in_time  = s_tdata[COUNT_WIDTH +: TIME_WIDTH];

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = have_sample_q ? ST_PREP : ST_RES;
			ST_PREP:  state_d = (dt_q == '0) ? ST_RES : ST_MUL;
			ST_MUL:   state_d = ST_DIV;
			ST_DIV:   if (div_cnt_q == '0) state_d = ST_SAT;
			ST_SAT:   state_d = ST_DELTA;
			ST_DELTA: state_d = ST_SMUL;
			ST_SMUL:  state_d = ST_UPD;
			ST_UPD:   state_d = ST_RES;
			ST_RES:   if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		cfg_ready = 1'b1;
		in_xfer   = s_tvalid && s_tready;
		out_load  = (state_q == ST_RES) && (!m_tvalid_q || m_tready);
	end

	// Subtractor of the divider: one quotient bit a cycle
	assign rem_sh   = {rem_q, num_q[NUM_W-1]};
	assign rem_diff = rem_sh - {1'b0, dt_q};
	assign rem_ge   = (rem_sh >= {1'b0, dt_q});

	// Clip the quotient and form the difference to the stored rate
	assign lim   = neg_q ? RATE_NEG_MAG : RATE_POS_MAX;
	assign over  = ovf_q || (quo_q > lim);
	assign qsat  = over ? lim : quo_q;
	assign delta = {inst_q[RATE_W-1], inst_q} - {smoothed_q[RATE_W-1], smoothed_q};

	// Weight above one counts as one
	assign w_eff   = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
	assign smul    = absd_q * w_eff;
	assign upd_sum = dneg_q ? ({smoothed_q[RATE_W-1], smoothed_q} - step_q)
	                        : ({smoothed_q[RATE_W-1], smoothed_q} + step_q);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			weight_q      <= WEIGHT_RESET;
			last_count_q  <= '0;
			last_time_q   <= '0;
			have_sample_q <= 1'b0;
			smoothed_q    <= '0;
			m_tvalid_q    <= 1'b0;
			div_cnt_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) weight_q <= cfg_data;
			// Record the sample on its transfer
			if (in_xfer) begin
				last_count_q  <= in_count;
				last_time_q   <= in_time;
				have_sample_q <= 1'b1;
				if (!have_sample_q) smoothed_q <= '0;
			end
			if (state_q == ST_UPD) smoothed_q <= upd_sum[RATE_W-1:0];
			if (state_q == ST_MUL) div_cnt_q <= DIV_LAST_STEP;
			else if (state_q == ST_DIV) div_cnt_q <= div_cnt_q - 1'b1;
			// Hold the result until it is taken
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dt_q     <= in_time - last_time_q;
				dv_q     <= in_count - last_count_q;
				status_q <= STAT_FIRST;
				sat_q    <= 1'b0;
			end
			ST_PREP: begin
				neg_q    <= dv_q[COUNT_WIDTH-1];
				mag_q    <= dv_q[COUNT_WIDTH-1] ? (~dv_q + 1'b1) : dv_q;
				status_q <= STAT_HELD;
			end
			ST_MUL: begin
				num_q <= {PROD_W'(mag_q) * US_PER_S, {FRAC_W{1'b0}}};
				rem_q <= '0;
				quo_q <= '0;
				ovf_q <= 1'b0;
			end
			ST_DIV: begin
				rem_q <= rem_ge ? rem_diff[TIME_WIDTH-1:0] : rem_sh[TIME_WIDTH-1:0];
				num_q <= {num_q[NUM_W-2:0], 1'b0};
				quo_q <= {quo_q[RATE_W-2:0], rem_ge};
				ovf_q <= ovf_q | quo_q[RATE_W-1];
			end
			ST_SAT: begin
				inst_q <= neg_q ? (~qsat + 1'b1) : qsat;
				sat_q  <= over;
			end
			ST_DELTA: begin
				dneg_q <= delta[DELTA_W-1];
				absd_q <= delta[DELTA_W-1] ? (~delta + 1'b1) : delta;
			end
			ST_SMUL: begin
				step_q <= smul[FRAC_W +: DELTA_W];
			end
			ST_UPD: begin
				status_q <= STAT_UPDATED;
			end
			default: begin
			end
		endcase
		// Output register
		if (out_load) begin
			m_rate_q   <= smoothed_q;
			m_status_q <= status_q;
			m_sat_q    <= sat_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_rate_q;
	assign m_tuser  = {m_sat_q, m_status_q};

`include "assert_macros.svh"

	`ASSERT_IMPL(a_first_zero, m_tvalid && (m_tuser[1:0] == STAT_FIRST), m_tdata == '0, "first-sample result carries a nonzero rate")
	`ASSERT_IMPL(a_sat_only_upd, m_tvalid && m_tuser[2], m_tuser[1:0] == STAT_UPDATED, "saturation flagged on a result that was not updated")
	`ASSERT_NEXT(a_div_ends, (state_q == ST_DIV) && (div_cnt_q == '0), state_q == ST_SAT, "divider did not hand over after its last step")
	`ASSERT_NEXT(a_busy_after_xfer, in_xfer, !s_tready, "sample taken while the previous one is still in work")

endmodule

// ----- dv/ewma_rate_estimator_core_test.sv -----
// Self-checking testbench of the EWMA rate estimator core: directed table, then random samples.
module ewma_rate_estimator_core_test;
	import ewma_rate_pkg::*;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		status_t           status;
		logic              sat;
	} rate_result_t;

	typedef struct {
		bit                  do_cfg;
		logic [WEIGHT_W-1:0] weight;
		logic [31:0]         count;
		logic [47:0]         stamp;
		bit                  typed;
		rate_result_t        res;
	} sample_row_t;

	localparam rate_result_t NO_RESULT = '0;
	localparam logic [127:0] US_SCALE_Q16 = 128'd65536000000;
	localparam logic [127:0] POS_LIMIT = 128'h7FFF_FFFF_FFFF;
	localparam logic [127:0] NEG_LIMIT = 128'h8000_0000_0000;

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [COUNT_WIDTH+TIME_WIDTH-1:0] s_tdata;
	logic                              m_tvalid;
	logic                              m_tready;
	logic [RATE_W-1:0]                 m_tdata;
	logic [2:0]                        m_tuser;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [WEIGHT_W-1:0]               cfg_data;

	// Predictor state: weight, previous sample and smoothed rate
	logic [WEIGHT_W-1:0] tb_weight;
	logic [31:0]         prev_count;
	logic [47:0]         prev_time;
	logic signed [63:0]  est_rate;
	bit                  have_sample;

	rate_result_t rate_due[$];
	int           mismatch_count;
	bit           quiet_sender;
	bit           quiet_receiver;

	// Directed samples; typed results only where they are obvious
	sample_row_t directed_rows [0:16] = '{
		'{1'b0, 17'd0,      32'h0000_0000, 48'h0,              1'b1,
			'{48'd0, STAT_FIRST, 1'b0}},
		'{1'b0, 17'd0,      32'h0000_0005, 48'h0,              1'b1,
			'{48'd0, STAT_HELD, 1'b0}},
		'{1'b1, 17'd65536,  32'h0000_0006, 48'h1,              1'b1,
			'{48'd65536000000, STAT_UPDATED, 1'b0}},
		'{1'b1, 17'd0,      32'h0000_0007, 48'h2,              1'b1,
			'{48'd65536000000, STAT_UPDATED, 1'b0}},
		'{1'b1, 17'd131071, 32'h0000_0009, 48'h4,              1'b1,
			'{48'd65536000000, STAT_UPDATED, 1'b0}},
		'{1'b0, 17'd0,      32'h8000_0008, 48'h5,              1'b1,
			'{48'h7FFF_FFFF_FFFF, STAT_UPDATED, 1'b1}},
		'{1'b0, 17'd0,      32'h0000_0008, 48'h6,              1'b1,
			'{48'h8000_0000_0000, STAT_UPDATED, 1'b1}},
		'{1'b0, 17'd0,      32'hFFFF_FFFF, 48'h7,              1'b0, NO_RESULT},
		'{1'b0, 17'd0,      32'h0000_0001, 48'h9,              1'b0, NO_RESULT},
		'{1'b0, 17'd0,      32'h0000_0001, 48'hFFFF_FFFF_FFFF, 1'b1,
			'{48'd0, STAT_UPDATED, 1'b0}},
		'{1'b0, 17'd0,      32'h0000_0004, 48'h2,              1'b0, NO_RESULT},
		'{1'b0, 17'd0,      32'h0000_0003, 48'h1,              1'b1,
			'{48'd0, STAT_UPDATED, 1'b0}},
		'{1'b1, 17'd8192,   32'h0000_0002, 48'h4,              1'b0, NO_RESULT},
		'{1'b0, 17'd0,      32'h0000_0002, 48'h4,              1'b0, NO_RESULT},
		'{1'b1, 17'd1,      32'h0000_03EA, 48'h7,              1'b0, NO_RESULT},
		'{1'b1, 17'd65535,  32'h7FFF_FFFF, 48'h8000_0000_0000, 1'b0, NO_RESULT},
		'{1'b0, 17'd0,      32'h8000_0000, 48'h8000_0000_0001, 1'b0, NO_RESULT}
	};

	ewma_rate_estimator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Advance the smoothed rate by one sample and return the result it gives
	function automatic rate_result_t predict_rate(logic [31:0] count, logic [47:0] stamp);
		logic [47:0]        elapsed;
		logic [31:0]        change;
		logic [31:0]        mag;
		logic               neg;
		logic [127:0]       quo;
		logic [63:0]        qv;
		logic [63:0]        dmag;
		logic [127:0]       step;
		logic [WEIGHT_W-1:0] w;
		logic signed [63:0] inst;
		logic signed [63:0] delta;
		rate_result_t       r;
		r = NO_RESULT;
		if (!have_sample) begin
			est_rate = 0;
			r.status = STAT_FIRST;
		end else begin
			elapsed = stamp - prev_time;
			if (elapsed == 0) begin
				r.status = STAT_HELD;
			end else begin
				// instantaneous rate, truncated, clipped to the 48-bit range
				change = count - prev_count;
				neg = change[31];
				mag = neg ? -change : change;
				quo = (128'(mag) * US_SCALE_Q16) / 128'(elapsed);
				if (quo > (neg ? NEG_LIMIT : POS_LIMIT)) begin
					quo = neg ? NEG_LIMIT : POS_LIMIT;
					r.sat = 1'b1;
				end
				qv = quo[63:0];
				inst = neg ? -$signed(qv) : $signed(qv);
				// move toward it by the clamped weight, truncated toward zero
				w = (tb_weight > 17'd65536) ? 17'd65536 : tb_weight;
				delta = inst - est_rate;
				dmag = (delta < 0) ? 64'(-delta) : 64'(delta);
				step = (128'(dmag) * 128'(w)) >> 16;
				if (delta < 0)
					est_rate = est_rate - $signed(step[63:0]);
				else
					est_rate = est_rate + $signed(step[63:0]);
				r.status = STAT_UPDATED;
			end
		end
		prev_count = count;
		prev_time = stamp;
		have_sample = 1'b1;
		r.rate = est_rate[RATE_W-1:0];
		return r;
	endfunction

	// Offer one sample after a random gap and queue its result on transfer
	task automatic send_sample(logic [31:0] count, logic [47:0] stamp,
			bit typed, rate_result_t typed_res);
		int           gap;
		rate_result_t want;
		gap = quiet_sender ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {stamp, count};
		do @(posedge clk); while (!s_tready);
		want = predict_rate(count, stamp);
		rate_due.push_back(typed ? typed_res : want);
		@(negedge clk);
	endtask

	// Hold the sender until every queued result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (rate_due.size() != 0) @(negedge clk);
	endtask

	// Write the smoothing weight while the core is idle
	task automatic write_weight(logic [WEIGHT_W-1:0] w);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= w;
		do @(posedge clk); while (!cfg_ready);
		tb_weight = w;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result sink: random stall per result, compare with the oldest prediction
	initial begin : result_sink
		int           stall;
		rate_result_t got;
		rate_result_t want;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = quiet_receiver ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got.rate = m_tdata;
			got.status = status_t'(m_tuser[1:0]);
			got.sat = m_tuser[2];
			if (rate_due.size() == 0) begin
				$error("unexpected result: rate %h status %0d saturated %0b",
					got.rate, got.status, got.sat);
				mismatch_count++;
			end else begin
				want = rate_due.pop_front();
				if (got.rate !== want.rate) begin
					$error("rate: expected %h, got %h", want.rate, got.rate);
					mismatch_count++;
				end
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					mismatch_count++;
				end
				if (got.sat !== want.sat) begin
					$error("saturated: expected %0b, got %0b", want.sat, got.sat);
					mismatch_count++;
				end
			end
			@(negedge clk);
		end
	end

	// Main sequence: reset, directed table, random phases, final verdict
	initial begin : stimulus
		logic [WEIGHT_W-1:0] phase_weight [0:7];
		logic [31:0]         count;
		logic [47:0]         stamp;
		logic [31:0]         jump;
		int                  kind;
		phase_weight = '{17'd0, 17'd65536, 17'd131071, 17'd1, 17'd65535,
			17'd0, 17'd0, 17'd8192};
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		tb_weight = WEIGHT_RESET;
		prev_count = '0;
		prev_time = '0;
		est_rate = 0;
		have_sample = 1'b0;
		mismatch_count = 0;
		quiet_sender = 1'b0;
		quiet_receiver = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// walk the directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].do_cfg)
				write_weight(directed_rows[i].weight);
			send_sample(directed_rows[i].count, directed_rows[i].stamp,
				directed_rows[i].typed, directed_rows[i].res);
		end

		// random phases, one weight each
		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 5 || phase == 6)
				phase_weight[phase] = 17'($urandom_range(0, 131071));
			write_weight(phase_weight[phase]);
			quiet_sender = (phase == 2 || phase == 6);
			quiet_receiver = (phase == 3 || phase == 6);
			for (int n = 0; n < 150; n++) begin
				kind = $urandom_range(0, 99);
				jump = 32'($urandom_range(0, 5000));
				if (kind < 60) begin
					// periodic timer with a plausible count change
					stamp = prev_time + 48'($urandom_range(1, 2000000));
					count = ($urandom_range(0, 3) == 0) ? prev_count - jump
						: prev_count + jump;
				end else if (kind < 70) begin
					stamp = prev_time;
					count = prev_count + jump;
				end else if (kind < 80) begin
					stamp = {16'($urandom), 32'($urandom)};
					count = $urandom;
				end else if (kind < 88) begin
					// tiny interval with a large change: drive saturation
					stamp = prev_time + 48'($urandom_range(1, 4));
					count = prev_count + $urandom;
				end else if (kind < 94) begin
					stamp = prev_time - 48'($urandom_range(1, 1000));
					count = prev_count + jump;
				end else begin
					case ($urandom_range(0, 3))
						0: count = 32'h0000_0000;
						1: count = 32'h7FFF_FFFF;
						2: count = 32'h8000_0000;
						default: count = 32'hFFFF_FFFF;
					endcase
					stamp = prev_time + 48'($urandom_range(1, 100));
				end
				if ($urandom_range(0, 59) == 0)
					drain_results();
				send_sample(count, stamp, 1'b0, NO_RESULT);
			end
		end

		drain_results();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("ewma_rate_estimator_core regression: pass");
		else
			$display("ewma_rate_estimator_core regression: fail");
		$finish;
	end

	// Guard against a hung handshake
	initial begin : watchdog
		#10_000_000;
		$display("ewma_rate_estimator_core regression: fail");
		$finish;
	end

endmodule
